// File: rtl/sabf_pkg.sv
// ----------------------------------------------------------------------------
// sabf_pkg
// Types, field widths, codes and helpers shared by the stack allocator
// with best-fit free list.
// ----------------------------------------------------------------------------
package sabf_pkg;

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int ALIGN_W = 17;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 3;
  localparam int MASK_W  = 17;
  localparam int SUM_W   = 51;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SAVE    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RESTORE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_REUSED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_LIST_FULL = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ALIGN_W-1:0] alignment;
    logic [SIZE_W-1:0]  size;
    logic [ADDR_W-1:0]  free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] committed_bytes;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // alignment rounded up to a power of two, returned as that power minus one
  function automatic logic [MASK_W-1:0] align_mask(input logic [ALIGN_W-1:0] alignment);
    logic [MASK_W-1:0] v;
    v = (alignment == '0) ? '0 : MASK_W'(alignment - 1'b1);
    v = v | (v >> 1);
    v = v | (v >> 2);
    v = v | (v >> 4);
    v = v | (v >> 8);
    v = v | (v >> 16);
    return v;
  endfunction

endpackage

// File: rtl/sabf_free_mem.sv
// ----------------------------------------------------------------------------
// sabf_free_mem
// Free-list storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sabf_free_mem #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IDX_W-1:0] waddr,
  input  sabf_pkg::entry_t wdata,
  input  logic [IDX_W-1:0] raddr,
  output sabf_pkg::entry_t rdata
);
  import sabf_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sabf_fit_eval.sv
// ----------------------------------------------------------------------------
// sabf_fit_eval
// Two-stage evaluation of one free-list entry per cycle, keeping the
// best fit seen since the last clear.
// ----------------------------------------------------------------------------
module sabf_fit_eval #(
  parameter int IDX_W = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          in_valid,
  input  logic [IDX_W-1:0]              in_idx,
  input  sabf_pkg::entry_t              in_entry,
  input  logic [sabf_pkg::MASK_W-1:0]   mask,
  input  logic [sabf_pkg::SIZE_W-1:0]   req_size,
  output logic                          busy,
  output logic                          found,
  output logic [IDX_W-1:0]              best_idx,
  output logic [sabf_pkg::ADDR_W-1:0]   best_addr
);
  import sabf_pkg::*;

  logic              e1_valid;
  logic [IDX_W-1:0]  e1_idx;
  logic [ADDR_W-1:0] e1_al;
  logic [MASK_W-1:0] e1_pad;
  logic [SIZE_W-1:0] e1_size;
  logic              e1_skip;
  logic [SIZE_W-1:0] best;

  logic [ADDR_W:0]   al_sum;
  logic [ADDR_W:0]   al;
  logic [MASK_W-1:0] pad;
  logic [SIZE_W:0]   diff;
  logic [SIZE_W-1:0] usable;
  logic              take;

  always_comb begin
    al_sum = {1'b0, in_entry.addr} + {{(ADDR_W+1-MASK_W){1'b0}}, mask};
    al     = al_sum & ~{{(ADDR_W+1-MASK_W){1'b0}}, mask};
    pad    = al[MASK_W-1:0] - in_entry.addr[MASK_W-1:0];
    diff   = {1'b0, e1_size} - {{(SIZE_W+1-MASK_W){1'b0}}, e1_pad};
    usable = diff[SIZE_W-1:0];
    take   = e1_valid && !e1_skip && !diff[SIZE_W] && (usable >= req_size)
             && (!found || usable <= best);
  end

  assign busy = e1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      e1_valid <= in_valid && !clear;
      if (clear) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
    e1_idx  <= in_idx;
    e1_al   <= al[ADDR_W-1:0];
    e1_pad  <= pad;
    e1_size <= in_entry.size;
    e1_skip <= al[ADDR_W];
    if (take) begin
      best      <= usable;
      best_idx  <= e1_idx;
      best_addr <= e1_al;
    end
  end

endmodule

// File: rtl/sabf_align_add.sv
// ----------------------------------------------------------------------------
// sabf_align_add
// Shared adder: sum with carry-in, low bits cleared by an alignment mask.
// ----------------------------------------------------------------------------
module sabf_align_add (
  input  logic [sabf_pkg::SUM_W-1:0]  a,
  input  logic [sabf_pkg::SUM_W-1:0]  b,
  input  logic                        cin,
  input  logic [sabf_pkg::MASK_W-1:0] m,
  output logic [sabf_pkg::SUM_W-1:0]  y
);
  import sabf_pkg::*;

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = a + b + SUM_W'(cin);
    y   = sum & ~{{(SUM_W-MASK_W){1'b0}}, m};
  end

endmodule

// File: rtl/stack_allocator_best_fit_free_list_unit.sv
// ----------------------------------------------------------------------------
// stack_allocator_best_fit_free_list_unit
// Stack arena allocator with a bounded best-fit free list, bump top offset,
// page-granular commit and one checkpoint.
// ----------------------------------------------------------------------------
//  channel  signals                       direction  transfer
//  req      req_valid, req_ready, req     in         valid & ready
//  rsp      rsp_valid, rsp_ready, rsp     out        valid & ready
//  cfg      cfg_we, cfg_wdata             in         cfg_we, arena_base
//
//  Allocate scans the free list, then takes the best fit through S_REUSE or
//  bumps the top through S_B_START to S_B_COMMIT; the scan reads one entry per cycle.
//  Free, checkpoint and unused codes go straight to S_DONE, pop through S_POP;
//  the next item can be accepted in the cycle after the result is loaded.
//  Reset clears all control state; free-list contents stay undefined.
//  A finished item waits in the rsp register while the next item is accepted;
//  the following result holds in S_DONE until that register is taken.
// ----------------------------------------------------------------------------
module stack_allocator_best_fit_free_list_unit #(
  parameter int FREE_ENTRIES = 64,
  parameter int OFFSET_BITS  = 32,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  sabf_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output sabf_pkg::rsp_t              rsp,
  input  logic                        cfg_we,
  input  logic [sabf_pkg::ADDR_W-1:0] cfg_wdata
);
  import sabf_pkg::*;

  localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
  localparam logic [MASK_W-1:0] PG_MASK = MASK_W'(PAGE_BYTES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_REUSE, S_B_START, S_B_ALIGN, S_B_END, S_B_EALIGN,
    S_B_DELTA, S_B_COMMIT, S_POP, S_DONE
  } state_t;

  state_t               state;
  logic [ADDR_W-1:0]    arena_base;
  logic [CNT_W-1:0]     count;
  logic [OFFSET_BITS-1:0] top;
  logic [OFFSET_BITS-1:0] checkpoint;
  logic [OFFSET_BITS-1:0] committed;
  logic [MASK_W-1:0]    it_mask;
  logic [SIZE_W-1:0]    it_size;
  logic [CNT_W-1:0]     scan_idx;
  logic                 pend;
  logic [IDX_W-1:0]     pend_idx;
  entry_t               last_entry;
  logic [SUM_W-1:0]     acc;
  logic [ADDR_W-1:0]    bump_start;
  logic                 end_ovf;
  logic [ADDR_W-1:0]    res_addr;
  logic [STAT_W-1:0]    res_status;

  logic                 accept;
  logic                 issue;
  logic                 rsp_load;
  logic [CNT_W-1:0]     last_idx;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;
  entry_t               rd_data;
  logic                 fit_clear;
  logic                 fit_busy;
  logic                 fit_found;
  logic [IDX_W-1:0]     fit_idx;
  logic [ADDR_W-1:0]    fit_addr;
  logic [SUM_W-1:0]     add_a;
  logic [SUM_W-1:0]     add_b;
  logic                 add_cin;
  logic [MASK_W-1:0]    add_m;
  logic [SUM_W-1:0]     add_y;
  logic [SUM_W-1:0]     top_ext;
  logic [SUM_W-1:0]     commit_ext;
  logic                 delta_ovf;
  logic                 commit_ovf;

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign issue      = (state == S_SCAN) && (scan_idx < count);
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign last_idx   = count - 1'b1;
  assign fit_clear  = accept;
  assign top_ext    = {{(SUM_W-OFFSET_BITS){1'b0}}, top};
  assign commit_ext = {{(SUM_W-OFFSET_BITS){1'b0}}, committed};
  assign delta_ovf  = acc[SUM_W-1:OFFSET_BITS] != '0;
  assign commit_ovf = add_y[SUM_W-1:OFFSET_BITS] != '0;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = '{addr: req.free_address, size: req.size};
    if (accept && req.func == FUNC_FREE && count < CNT_W'(FREE_ENTRIES)) begin
      mem_we = 1'b1;
    end else if (state == S_REUSE) begin
      mem_we    = 1'b1;
      mem_waddr = fit_idx;
      mem_wdata = last_entry;
    end
  end

  always_comb begin
    add_a   = acc;
    add_b   = '0;
    add_cin = 1'b0;
    add_m   = '0;
    case (state)
      S_B_START: begin
        add_a = {{(SUM_W-ADDR_W){1'b0}}, arena_base};
        add_b = top_ext;
      end
      S_B_ALIGN, S_B_EALIGN: begin
        add_b = {{(SUM_W-MASK_W){1'b0}}, it_mask};
        add_m = it_mask;
      end
      S_B_END: begin
        add_b = {{(SUM_W-SIZE_W){1'b0}}, it_size};
      end
      S_B_DELTA: begin
        add_b   = ~{{(SUM_W-ADDR_W){1'b0}}, arena_base};
        add_cin = 1'b1;
      end
      S_B_COMMIT: begin
        add_b = {{(SUM_W-MASK_W){1'b0}}, PG_MASK};
        add_m = PG_MASK;
      end
      S_POP: begin
        add_a   = top_ext;
        add_b   = ~{{(SUM_W-SIZE_W){1'b0}}, it_size};
        add_cin = 1'b1;
      end
      default: begin
        add_a = acc;
      end
    endcase
  end

  sabf_free_mem #(
    .DEPTH (FREE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_data)
  );

  sabf_fit_eval #(
    .IDX_W (IDX_W)
  ) u_fit (
    .clk       (clk),
    .rst       (rst),
    .clear     (fit_clear),
    .in_valid  (pend),
    .in_idx    (pend_idx),
    .in_entry  (rd_data),
    .mask      (it_mask),
    .req_size  (it_size),
    .busy      (fit_busy),
    .found     (fit_found),
    .best_idx  (fit_idx),
    .best_addr (fit_addr)
  );

  sabf_align_add u_add (
    .a   (add_a),
    .b   (add_b),
    .cin (add_cin),
    .m   (add_m),
    .y   (add_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      arena_base <= '0;
      count      <= '0;
      top        <= '0;
      checkpoint <= '0;
      committed  <= OFFSET_BITS'(PAGE_BYTES);
      pend       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        arena_base <= cfg_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      pend <= issue;
      case (state)
        S_IDLE: begin
          if (accept) begin
            it_mask  <= align_mask(req.alignment);
            it_size  <= req.size;
            scan_idx <= '0;
            res_addr <= '0;
            case (req.func)
              FUNC_ALLOC: begin
                res_status <= ST_DONE;
                state      <= S_SCAN;
              end
              FUNC_FREE: begin
                if (count < CNT_W'(FREE_ENTRIES)) begin
                  count      <= count + 1'b1;
                  res_status <= ST_DONE;
                end else begin
                  res_status <= ST_LIST_FULL;
                end
                state <= S_DONE;
              end
              FUNC_POP: begin
                res_status <= ST_DONE;
                state      <= S_POP;
              end
              FUNC_SAVE: begin
                checkpoint <= top;
                res_status <= ST_DONE;
                state      <= S_DONE;
              end
              FUNC_RESTORE: begin
                top        <= checkpoint;
                res_status <= ST_DONE;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (pend && pend_idx == last_idx[IDX_W-1:0]) begin
            last_entry <= rd_data;
          end
          if (!issue && !pend && !fit_busy) begin
            state <= fit_found ? S_REUSE : S_B_START;
          end
        end
        S_REUSE: begin
          count      <= count - 1'b1;
          res_addr   <= fit_addr;
          res_status <= ST_REUSED;
          state      <= S_DONE;
        end
        S_B_START: begin
          acc   <= add_y;
          state <= S_B_ALIGN;
        end
        S_B_ALIGN: begin
          acc        <= add_y;
          bump_start <= add_y[ADDR_W-1:0];
          state      <= S_B_END;
        end
        S_B_END: begin
          acc   <= add_y;
          state <= S_B_EALIGN;
        end
        S_B_EALIGN: begin
          acc   <= add_y;
          state <= S_B_DELTA;
        end
        S_B_DELTA: begin
          end_ovf <= acc[SUM_W-1:ADDR_W] != '0;
          acc     <= add_y;
          state   <= S_B_COMMIT;
        end
        S_B_COMMIT: begin
          if (end_ovf || delta_ovf || commit_ovf) begin
            res_status <= ST_OVERFLOW;
          end else begin
            top      <= acc[OFFSET_BITS-1:0];
            res_addr <= bump_start;
            if (acc > commit_ext) begin
              committed <= add_y[OFFSET_BITS-1:0];
            end
          end
          state <= S_DONE;
        end
        S_POP: begin
          if (add_y[SUM_W-1]) begin
            res_status <= ST_UNDERFLOW;
          end else begin
            top <= add_y[OFFSET_BITS-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    pend_idx <= scan_idx[IDX_W-1:0];
    if (rsp_load) begin
      rsp.address         <= res_addr;
      rsp.status          <= res_status;
      rsp.committed_bytes <= commit_ext[SIZE_W-1:0];
    end
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stack allocator with best-fit free list
// Drives allocate, free, pop and checkpoint items through the valid/ready
// request channel under random gaps and response stalls. An item-level
// arena model predicts each response; responses are checked in order, field
// by field. The arena base is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import sabf_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int OFS_BITS   = 32;
  localparam int PAGE       = 4096;
  localparam int LIMIT      = 1000000;
  localparam int PHASES     = 6;

  localparam logic [63:0] ADDR_LIMIT   = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] OFFSET_LIMIT = 64'hFFFF_FFFF;

  localparam logic [FUNC_W-1:0] FUNC_RSVD_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_B = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_C = 3'd7;

  typedef enum logic [1:0] {MIX_BALANCED, MIX_FREE_HEAVY, MIX_ALLOC_HEAVY} mix_t;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_t              rsp;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  // arena model state
  logic [ADDR_W-1:0] arena_base_q;
  logic [ADDR_W-1:0] blk_addr [LIST_DEPTH];
  logic [SIZE_W-1:0] blk_size [LIST_DEPTH];
  int                blk_count;
  logic [63:0]       top_q;
  logic [63:0]       ckpt_q;
  logic [63:0]       commit_q;

  rsp_t      owed_rsp [$];
  entry_t    live_blocks [$];
  plan_row_t plan [$];
  int        fail_count;
  int        rsp_seen;
  int        cycles;
  bit        calm;

  stack_allocator_best_fit_free_list_unit #(
    .FREE_ENTRIES(LIST_DEPTH),
    .OFFSET_BITS (OFS_BITS),
    .PAGE_BYTES  (PAGE)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic rsp_t arena_step(req_t it);
    rsp_t              res;
    logic [63:0]       a, sz, lo, al, pad, usable, best;
    logic [63:0]       raw_start, bump_start, end_new, delta, grow;
    logic [ADDR_W-1:0] tmp_addr;
    logic [SIZE_W-1:0] tmp_size;
    int                pick, last;
    bit                found;
    res = '0;
    res.status = ST_DONE;
    sz = 64'(it.size);
    case (it.func)
      FUNC_ALLOC: begin
        a = 64'd1;
        while (a < 64'(it.alignment)) a = a << 1;
        found = 1'b0;
        pick = 0;
        best = '0;
        for (int i = 0; i < blk_count; i++) begin
          lo = 64'(blk_addr[i]);
          al = (lo + a - 64'd1) & ~(a - 64'd1);
          pad = al - lo;
          if (pad > 64'(blk_size[i]) || al > ADDR_LIMIT) continue;
          usable = 64'(blk_size[i]) - pad;
          if (usable >= sz && (!found || usable <= best)) begin
            found = 1'b1;
            best = usable;
            pick = i;
            res.address = al[ADDR_W-1:0];
          end
        end
        if (found) begin
          last = blk_count - 1;
          tmp_addr = blk_addr[last];
          tmp_size = blk_size[last];
          blk_addr[last] = blk_addr[pick];
          blk_size[last] = blk_size[pick];
          blk_addr[pick] = tmp_addr;
          blk_size[pick] = tmp_size;
          blk_count = last;
          res.status = ST_REUSED;
        end else begin
          raw_start = 64'(arena_base_q) + top_q;
          bump_start = (raw_start + a - 64'd1) & ~(a - 64'd1);
          end_new = (bump_start + sz + a - 64'd1) & ~(a - 64'd1);
          delta = end_new - 64'(arena_base_q);
          grow = commit_q;
          if (delta > commit_q)
            grow = commit_q + ((delta - commit_q + PAGE - 1) / PAGE) * PAGE;
          if (end_new > ADDR_LIMIT || delta > OFFSET_LIMIT || grow > OFFSET_LIMIT) begin
            res.status = ST_OVERFLOW;
          end else begin
            commit_q = grow;
            top_q = delta;
            res.address = bump_start[ADDR_W-1:0];
          end
        end
      end
      FUNC_FREE: begin
        if (blk_count < LIST_DEPTH) begin
          blk_addr[blk_count] = it.free_address;
          blk_size[blk_count] = it.size;
          blk_count++;
        end else begin
          res.status = ST_LIST_FULL;
        end
      end
      FUNC_POP: begin
        if (top_q >= sz) top_q = top_q - sz;
        else res.status = ST_UNDERFLOW;
      end
      FUNC_SAVE:    ckpt_q = top_q;
      FUNC_RESTORE: top_q = ckpt_q;
      default: ;
    endcase
    res.committed_bytes = commit_q[SIZE_W-1:0];
    return res;
  endfunction

  function automatic plan_row_t step_row(logic [FUNC_W-1:0] f, logic [ALIGN_W-1:0] al,
                                         logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] fa,
                                         bit typed = 1'b0, rsp_t want = '0);
    plan_row_t r;
    r.item.func = f;
    r.item.alignment = al;
    r.item.size = sz;
    r.item.free_address = fa;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic req_t draw_item(mix_t mix);
    req_t        it;
    entry_t      blk;
    logic [63:0] w;
    int          r, k, cut_alloc, cut_free;
    w = {$urandom, $urandom};
    it.free_address = w[ADDR_W-1:0];
    case ($urandom_range(0, 3))
      0: it.alignment = 17'd1 << $urandom_range(0, 16);
      1: it.alignment = 17'($urandom_range(0, 100));
      2: it.alignment = 17'($urandom);
      default: it.alignment = (17'd1 << $urandom_range(0, 16)) + 17'($urandom_range(0, 3));
    endcase
    r = $urandom_range(0, 9);
    if (r < 6) it.size = $urandom_range(0, 600);
    else if (r < 9) it.size = $urandom_range(0, 20000);
    else it.size = $urandom;
    case (mix)
      MIX_FREE_HEAVY:  begin cut_alloc = 25; cut_free = 85; end
      MIX_ALLOC_HEAVY: begin cut_alloc = 60; cut_free = 80; end
      default:         begin cut_alloc = 40; cut_free = 70; end
    endcase
    r = $urandom_range(0, 99);
    if (r < cut_alloc) begin
      it.func = FUNC_ALLOC;
    end else if (r < cut_free) begin
      it.func = FUNC_FREE;
      r = $urandom_range(0, 3);
      if (live_blocks.size() != 0 && r != 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[k];
        live_blocks.delete(k);
        it.free_address = blk.addr;
        it.size = blk.size;
      end else if (r != 0) begin
        it.free_address = arena_base_q + top_q[ADDR_W-1:0] + ADDR_W'($urandom_range(0, 4095));
        it.size = $urandom_range(0, 2048);
      end
    end else begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        it.func = FUNC_POP;
        if ($urandom_range(0, 3) != 0) it.size = $urandom_range(0, top_q[SIZE_W-1:0]);
      end else if (r < 6) begin
        it.func = FUNC_SAVE;
      end else if (r < 8) begin
        it.func = FUNC_RESTORE;
      end else begin
        case ($urandom_range(0, 2))
          0: it.func = FUNC_RSVD_A;
          1: it.func = FUNC_RSVD_B;
          default: it.func = FUNC_RSVD_C;
        endcase
      end
    end
    return it;
  endfunction

  task automatic send_item(req_t it, bit typed, rsp_t want);
    int   gap;
    rsp_t res;
    gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    res = arena_step(it);
    owed_rsp.push_back(typed ? want : res);
    if (it.func == FUNC_ALLOC && res.status != ST_OVERFLOW && it.size != '0) begin
      live_blocks.push_back('{res.address, it.size});
      if (live_blocks.size() > 32) void'(live_blocks.pop_front());
    end
  endtask

  // hold the request side until every owed response is back
  task automatic drain_owed();
    req_valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (fail_count <= 100)
      $display("ERROR rsp %0d %s: got 0x%0h want 0x%0h", rsp_seen, what, got, want);
  endtask

  initial begin : rsp_stall
    int hold;
    hold = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        rsp_ready <= 1'b0;
        hold--;
      end else begin
        rsp_ready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (owed_rsp.size() == 0) begin
        flag_mismatch("unexpected item", 64'(rsp), 64'd0);
      end else begin
        want = owed_rsp.pop_front();
        if (rsp.address !== want.address)
          flag_mismatch("address", 64'(rsp.address), 64'(want.address));
        if (rsp.status !== want.status)
          flag_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.committed_bytes !== want.committed_bytes)
          flag_mismatch("committed_bytes", 64'(rsp.committed_bytes),
                        64'(want.committed_bytes));
      end
      rsp_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] ph_base  [PHASES];
    mix_t              ph_mix   [PHASES];
    bit                ph_calm  [PHASES];
    int                ph_items [PHASES];
    logic [63:0]       w;
    fail_count = 0;
    rsp_seen = 0;
    cycles = 0;
    calm = 1'b0;
    arena_base_q = '0;
    blk_count = 0;
    top_q = '0;
    ckpt_q = '0;
    commit_q = 64'(PAGE);
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;

    plan.push_back(step_row(FUNC_POP, 17'd1, 32'd1, 48'd0, 1'b1,
                            '{48'd0, ST_UNDERFLOW, 32'd4096}));
    plan.push_back(step_row(FUNC_POP, 17'd1, 32'd0, 48'd0, 1'b1,
                            '{48'd0, ST_DONE, 32'd4096}));
    plan.push_back(step_row(FUNC_SAVE, 17'd0, 32'd0, 48'd0, 1'b1,
                            '{48'd0, ST_DONE, 32'd4096}));
    plan.push_back(step_row(FUNC_ALLOC, 17'd0, 32'd0, 48'd0, 1'b1,
                            '{48'd0, ST_DONE, 32'd4096}));
    plan.push_back(step_row(FUNC_ALLOC, 17'd1, 32'd4096, 48'd0, 1'b1,
                            '{48'd0, ST_DONE, 32'd4096}));
    plan.push_back(step_row(FUNC_ALLOC, 17'd65536, 32'd1, 48'd0, 1'b1,
                            '{48'd65536, ST_DONE, 32'd131072}));
    plan.push_back(step_row(FUNC_ALLOC, 17'd1, 32'hFFFF_FFFF, 48'd0, 1'b1,
                            '{48'd0, ST_OVERFLOW, 32'd131072}));
    plan.push_back(step_row(FUNC_ALLOC, 17'h1FFFF, 32'd3, 48'hFFFF_FFFF_FFFF));
    plan.push_back(step_row(FUNC_FREE, 17'd1, 32'h100, 48'h1000));
    plan.push_back(step_row(FUNC_FREE, 17'h1FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    plan.push_back(step_row(FUNC_FREE, 17'd1, 32'h10, 48'hFFFF_FFFF_FF00));
    plan.push_back(step_row(FUNC_FREE, 17'd1, 32'h10, 48'h2001));
    plan.push_back(step_row(FUNC_ALLOC, 17'd16, 32'h10, 48'd0));
    plan.push_back(step_row(FUNC_ALLOC, 17'd512, 32'd8, 48'd0));
    plan.push_back(step_row(FUNC_FREE, 17'd1, 32'h40, 48'h3000));
    plan.push_back(step_row(FUNC_FREE, 17'd1, 32'h40, 48'h4000));
    plan.push_back(step_row(FUNC_ALLOC, 17'd1, 32'h40, 48'd0));
    plan.push_back(step_row(FUNC_RESTORE, 17'd1, 32'd0, 48'd0));
    plan.push_back(step_row(FUNC_ALLOC, 17'd1, 32'hFFFF_FFF0, 48'd0));
    plan.push_back(step_row(FUNC_ALLOC, 17'd1, 32'hFFFF_E000, 48'd0));
    plan.push_back(step_row(FUNC_POP, 17'd1, 32'hFFFF_E000, 48'd0));
    plan.push_back(step_row(FUNC_RSVD_A, 17'h1FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    plan.push_back(step_row(FUNC_RSVD_B, 17'd3, 32'd7, 48'h5));
    plan.push_back(step_row(FUNC_RSVD_C, 17'd0, 32'd0, 48'd0));
    plan.push_back(step_row(FUNC_POP, 17'd1, 32'd1, 48'd0));

    w = {$urandom, $urandom};
    ph_base[0] = '0;
    ph_base[1] = w[ADDR_W-1:0] & ~48'hFFF;
    ph_base[2] = 48'hFFFF_FFFF_FFFF;
    ph_base[3] = 48'h0000_0010_0000;
    w = {$urandom, $urandom};
    ph_base[4] = w[ADDR_W-1:0];
    ph_base[5] = 48'h0000_7FFF_F000;
    ph_mix = '{MIX_BALANCED, MIX_FREE_HEAVY, MIX_FREE_HEAVY,
               MIX_BALANCED, MIX_ALLOC_HEAVY, MIX_BALANCED};
    ph_calm = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    ph_items = '{200, 200, 150, 150, 250, 200};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);
    drain_owed();

    for (int p = 0; p < PHASES; p++) begin
      cfg_wdata <= ph_base[p];
      cfg_we <= 1'b1;
      @(posedge clk);
      arena_base_q = ph_base[p];
      cfg_we <= 1'b0;
      repeat (2) @(posedge clk);
      calm = ph_calm[p];
      repeat (ph_items[p]) send_item(draw_item(ph_mix[p]), 1'b0, '0);
      drain_owed();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && owed_rsp.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
